/* sv/cma_pkg.sv */
package cma_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_WINDOW_DEF   = 63;

  localparam int WIN_W     = 6;
  localparam int HALF_W    = WIN_W - 1;
  localparam int RECIP_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 1;

  // result buffer depth, power of two
  localparam int FIFO_DEPTH = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RECIP = 1'b1;

  localparam logic [WIN_W-1:0]   WIN_LEN_RST = 6'd5;
  localparam logic [RECIP_W-1:0] RECIP_RST   = 17'd13107;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } ctl_state_e;

  // one write into the delay line
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    logic clear;
    logic zero;
  } push_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctl_t;

endpackage

/* sv/centered_moving_average_top.sv */
// Channel   Dir  Beat fields (low bit up)             Handshake
// s_axis    in   tdata: sample; tlast: series_end     tvalid/tready
// m_axis    out  tdata: mean;   tlast: last           tvalid/tready
// cfg       in   idx 0 window_length, 1 reciprocal    cfg_we_i, no wait
//
// One sample or one flushed mean per cycle unless a resum runs or credit is out;
// a beat passes the read, sum and product registers and the output buffer to reach
// m_axis. After a series end the block flushes means with s_axis_tready low. Up
// to eight means may be outstanding before input stalls. A window_length write
// resums the window from memory with s_axis_tready low. Reset clears control only;
// the delay line memory is not swept, stale entries are masked by a fill count.
module centered_moving_average_top import cma_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,   // sample
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,   // mean
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RECIP_W-1:0]   cfg_data_i
);

  localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW + 1);

  logic                    busy, win_wr, pop;
  logic [WIN_W-1:0]        win;
  logic [RECIP_W-1:0]      recip;
  push_ctl_t               push;
  logic signed [SUM_W-1:0] sum;
  beat_ctl_t               sum_ctl, mean_ctl;
  logic [SAMPLE_WIDTH-1:0] mean, out_mean;

  assign pop = m_axis_tvalid && m_axis_tready;

  cma_ctrl #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .busy_i    (busy),
    .out_pop_i (pop),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .win_o     (win),
    .win_wr_o  (win_wr),
    .recip_o   (recip),
    .push_o    (push)
  );

  cma_line #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .win_i    (win),
    .win_wr_i (win_wr),
    .busy_o   (busy),
    .sum_o    (sum),
    .sum_ctl_o(sum_ctl)
  );

  cma_mean #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_mean (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sum_i     (sum),
    .sum_ctl_i (sum_ctl),
    .recip_i   (recip),
    .mean_o    (mean),
    .mean_ctl_o(mean_ctl)
  );

  cma_ofifo #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ofifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_ctl_i   (mean_ctl),
    .wr_mean_i  (mean),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_mean_o (out_mean),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'(out_mean);

endmodule

/* sv/cma_ctrl.sv */
module cma_ctrl import cma_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_last_i,
  output logic                 s_ready_o,
  input  logic                 busy_i,
  input  logic                 out_pop_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RECIP_W-1:0]   cfg_data_i,
  output logic [WIN_W-1:0]     win_o,
  output logic                 win_wr_o,
  output logic [RECIP_W-1:0]   recip_o,
  output push_ctl_t            push_o
);

  localparam int WIN_LIM = (MAX_WINDOW - 1) | 1;
  localparam int CRED_W  = $clog2(FIFO_DEPTH + 1);

  logic [WIN_W-1:0]   win_len_q, win_odd, win_eff;
  logic [RECIP_W-1:0] recip_q;
  ctl_state_e         state_q, state_d;
  logic [CNT_W-1:0]   seen_q, seen_d, seen_inc;
  logic [HALF_W-1:0]  flush_q, flush_d, half, flush_cnt;
  logic [CRED_W-1:0]  cred_q, cred_d;
  logic               cred_ok, emit_s, take;
  push_ctl_t          push;

  assign win_odd = win_len_q | WIN_W'(1);
  assign win_eff = (int'(win_odd) > WIN_LIM) ? WIN_W'(WIN_LIM) : win_odd;
  assign half    = win_eff[WIN_W-1:1];

  assign seen_inc  = (seen_q == '1) ? seen_q : seen_q + CNT_W'(1);
  assign flush_cnt = (seen_inc < CNT_W'(half)) ? seen_inc[HALF_W-1:0] : half;
  assign emit_s    = seen_inc > CNT_W'(half);
  assign cred_ok   = cred_q < CRED_W'(FIFO_DEPTH);

  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    flush_d   = flush_q;
    push      = '0;
    s_ready_o = 1'b0;
    take      = 1'b0;
    case (state_q)
      ST_RUN: begin
        s_ready_o = !busy_i && cred_ok;
        take      = s_valid_i && s_ready_o;
        if (take) begin
          push.valid = 1'b1;
          push.emit  = emit_s;
          push.last  = s_last_i && (flush_cnt == '0);
          push.clear = s_last_i && (flush_cnt == '0);
          if (s_last_i) begin
            seen_d = '0;
            if (flush_cnt != '0) begin
              flush_d = flush_cnt;
              state_d = ST_FLUSH;
            end
          end else begin
            seen_d = seen_inc;
          end
        end
      end
      ST_FLUSH: begin
        // shift in zeros, one mean per cycle while output credit remains
        if (cred_ok) begin
          push.valid = 1'b1;
          push.emit  = 1'b1;
          push.zero  = 1'b1;
          push.last  = flush_q == HALF_W'(1);
          push.clear = flush_q == HALF_W'(1);
          flush_d    = flush_q - HALF_W'(1);
          if (flush_q == HALF_W'(1)) begin
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    cred_d = cred_q;
    case ({push.valid && push.emit, out_pop_i})
      2'b10:   cred_d = cred_q + CRED_W'(1);
      2'b01:   cred_d = cred_q - CRED_W'(1);
      default: cred_d = cred_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      seen_q  <= '0;
      flush_q <= '0;
      cred_q  <= '0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      flush_q <= flush_d;
      cred_q  <= cred_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_LEN_RST;
      recip_q   <= RECIP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIN_LEN:   win_len_q <= cfg_data_i[WIN_W-1:0];
        REG_WIN_RECIP: recip_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign win_o    = win_eff;
  assign win_wr_o = cfg_we_i && (cfg_idx_i == REG_WIN_LEN);
  assign recip_o  = recip_q;
  assign push_o   = push;

endmodule

/* sv/cma_line.sv */
module cma_line import cma_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  push_ctl_t                             push_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  logic [WIN_W-1:0]                      win_i,
  input  logic                                  win_wr_i,
  output logic                                  busy_o,
  output logic signed [SAMPLE_WIDTH+$clog2(MAX_WINDOW+1)-1:0] sum_o,
  output beat_ctl_t                             sum_ctl_o
);

  localparam int AW    = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = 1 << AW;
  localparam int SUM_W = SAMPLE_WIDTH + AW;
  localparam int LW    = (AW > WIN_W) ? AW : WIN_W;

  logic signed [SAMPLE_WIDTH-1:0] mem_q [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] rd_q, x_q, wr_data;
  logic [AW-1:0]                  wp_q, fill_q, fill_d, rd_addr;
  logic [LW-1:0]                  win_l, fill_l, k_l, addr_drop, addr_sweep;
  logic                           drop_ok_q, s1_valid_q, s1_emit_q, s1_last_q, s1_clear_q;
  logic signed [SUM_W-1:0]        sum_q, sum_d, sum_new, drop_val;
  logic                           sw_act_q, sw_act_d, sw_rd_q, sw_rd_d, sw_ok_q, sw_ok_d;
  logic [WIN_W-1:0]               sw_k_q, sw_k_d;

  assign win_l  = LW'(win_i);
  assign fill_l = LW'(fill_q);
  assign k_l    = LW'(sw_k_q);

  // newest entry sits at wp_q - 1; the one leaving the window at wp_q - W
  assign addr_drop  = LW'(wp_q) - win_l;
  assign addr_sweep = LW'(wp_q) - k_l - LW'(1);
  assign rd_addr    = sw_act_q ? addr_sweep[AW-1:0] : addr_drop[AW-1:0];
  assign wr_data    = push_i.zero ? '0 : sample_i;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wp_q] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
    x_q  <= wr_data;
  end

  // entries older than the fill count read as zero
  always_comb begin
    fill_d = fill_q;
    if (push_i.valid) begin
      if (push_i.clear) begin
        fill_d = '0;
      end else if (fill_q != AW'(MAX_WINDOW)) begin
        fill_d = fill_q + AW'(1);
      end
    end
  end

  assign drop_val = drop_ok_q ? SUM_W'(rd_q) : '0;
  assign sum_new  = sum_q + SUM_W'(x_q) - drop_val;

  // resum the window after a window length write
  always_comb begin
    sw_act_d = sw_act_q;
    sw_k_d   = sw_k_q;
    sw_rd_d  = 1'b0;
    sw_ok_d  = 1'b0;
    if (win_wr_i) begin
      sw_act_d = 1'b1;
      sw_k_d   = '0;
    end else if (sw_act_q) begin
      if (k_l < win_l) begin
        sw_rd_d = 1'b1;
        sw_ok_d = k_l < fill_l;
        sw_k_d  = sw_k_q + WIN_W'(1);
      end else if (!sw_rd_q) begin
        sw_act_d = 1'b0;
      end
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (win_wr_i) begin
      sum_d = '0;
    end else if (sw_act_q) begin
      if (sw_rd_q && sw_ok_q) begin
        sum_d = sum_q + SUM_W'(rd_q);
      end
    end else if (s1_valid_q) begin
      sum_d = s1_clear_q ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      fill_q     <= '0;
      drop_ok_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_clear_q <= 1'b0;
      sum_q      <= '0;
      sw_act_q   <= 1'b0;
      sw_rd_q    <= 1'b0;
      sw_ok_q    <= 1'b0;
      sw_k_q     <= '0;
    end else begin
      if (push_i.valid) begin
        wp_q <= wp_q + AW'(1);
      end
      fill_q     <= fill_d;
      drop_ok_q  <= win_l <= fill_l;
      s1_valid_q <= push_i.valid;
      s1_emit_q  <= push_i.emit;
      s1_last_q  <= push_i.last;
      s1_clear_q <= push_i.clear;
      sum_q      <= sum_d;
      sw_act_q   <= sw_act_d;
      sw_rd_q    <= sw_rd_d;
      sw_ok_q    <= sw_ok_d;
      sw_k_q     <= sw_k_d;
    end
  end

  assign busy_o          = sw_act_q || win_wr_i;
  assign sum_o           = sum_new;
  assign sum_ctl_o.valid = s1_valid_q && s1_emit_q;
  assign sum_ctl_o.last  = s1_last_q;

endmodule

/* sv/cma_mean.sv */
module cma_mean import cma_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [SAMPLE_WIDTH+$clog2(MAX_WINDOW+1)-1:0] sum_i,
  input  beat_ctl_t                             sum_ctl_i,
  input  logic [RECIP_W-1:0]                    recip_i,
  output logic [SAMPLE_WIDTH-1:0]               mean_o,
  output beat_ctl_t                             mean_ctl_o
);

  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW + 1);
  localparam int PROD_W = SUM_W + RECIP_W + 1;
  localparam int RND_W  = PROD_W + 1;
  localparam int Q_W    = RND_W - FRAC_W;

  localparam logic [Q_W-1:0] POS_LIM = {{(Q_W-SAMPLE_WIDTH+1){1'b0}},
                                        {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_LIM = POS_LIM + Q_W'(1);

  logic signed [SUM_W-1:0]  a_sum_q;
  logic signed [PROD_W-1:0] prod_q;
  beat_ctl_t                a_q, b_q;
  logic                     neg;
  logic [PROD_W-1:0]        mag;
  logic [RND_W-1:0]         rnd;
  logic [Q_W-1:0]           quo;
  logic [SAMPLE_WIDTH-1:0]  res;

  always_ff @(posedge clk_i) begin
    a_sum_q <= sum_i;
    prod_q  <= a_sum_q * $signed({1'b0, recip_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else begin
      a_q <= sum_ctl_i;
      b_q <= a_q;
    end
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    neg = prod_q[PROD_W-1];
    mag = neg ? ($unsigned(~prod_q) + PROD_W'(1)) : $unsigned(prod_q);
    rnd = RND_W'(mag) + (RND_W'(1) << (FRAC_W - 1));
    quo = rnd[RND_W-1:FRAC_W];
    if (neg) begin
      res    = (quo > NEG_LIM) ? NEG_LIM[SAMPLE_WIDTH-1:0] : quo[SAMPLE_WIDTH-1:0];
      mean_o = ~res + SAMPLE_WIDTH'(1);
    end else begin
      res    = (quo > POS_LIM) ? POS_LIM[SAMPLE_WIDTH-1:0] : quo[SAMPLE_WIDTH-1:0];
      mean_o = res;
    end
  end

  assign mean_ctl_o = b_q;

endmodule

/* sv/cma_ofifo.sv */
module cma_ofifo import cma_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  beat_ctl_t               wr_ctl_i,
  input  logic [SAMPLE_WIDTH-1:0] wr_mean_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SAMPLE_WIDTH-1:0] out_mean_o,
  output logic                    out_last_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [SAMPLE_WIDTH:0] buf_q [FIFO_DEPTH];
  logic [PW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]         cnt_q;
  logic                  wr, rd;

  assign wr = wr_ctl_i.valid;
  assign rd = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wr_ptr_q] <= {wr_ctl_i.last, wr_mean_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (rd) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      case ({wr, rd})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_mean_o  = buf_q[rd_ptr_q][SAMPLE_WIDTH-1:0];
  assign out_last_o  = buf_q[rd_ptr_q][SAMPLE_WIDTH];

endmodule
